### hw/rtl/turtle_command_interpreter_unit_assert.svh
// assertion macros used by the turtle interpreter datapath
`ifndef TURTLE_COMMAND_INTERPRETER_UNIT_ASSERT_SVH
`define TURTLE_COMMAND_INTERPRETER_UNIT_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define TCI_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tci_pkg.sv
// shared types, constants and helper functions of the turtle interpreter
package tci_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int POS_BITS        = 40;

    localparam logic [1:0] KIND_SEGMENT   = 2'd0;
    localparam logic [1:0] KIND_UNDERFLOW = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [POS_BITS-1:0] start_x;
        logic signed [POS_BITS-1:0] start_y;
        logic signed [POS_BITS-1:0] end_x;
        logic signed [POS_BITS-1:0] end_y;
        logic                       last;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_DIGIT,
        OP_DRAW,
        OP_REP_CLEAR,
        OP_MUL_X,
        OP_ADD_X,
        OP_ADD_Y,
        OP_EMIT_SEG,
        OP_HOME,
        OP_ORIGIN,
        OP_PUSH_INIT,
        OP_PUSH,
        OP_POP_RD,
        OP_POP_LD,
        OP_TURN_L,
        OP_TURN_R,
        OP_EMIT_ERR
    } dp_op_t;

    // controller to datapath
    typedef struct packed {
        dp_op_t     op;
        logic       snap;
        logic       move_dist;
        logic [3:0] digit;
        logic       seg_last;
        logic [1:0] err_kind;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pending_nz;
        logic push_ovf;
        logic pop_unf;
        logic rep_zero;
        logic push_done;
        logic out_free;
    } dp_stat_t;

    // sine of a 15-degree multiple, rounded half up to frac fraction bits
    function automatic longint trig_q(input int idx, input int frac);
        longint v;
        case (idx)
            0:       v = 64'd0;
            1:       v = 64'd25882;
            2:       v = 64'd50000;
            3:       v = 64'd70711;
            4:       v = 64'd86603;
            5:       v = 64'd96593;
            default: v = 64'd100000;
        endcase
        return ((v << frac) + 64'd50000) / 64'd100000;
    endfunction

    // remainder by 24 of a value below 256
    function automatic logic [4:0] mod24(input logic [7:0] x);
        logic [4:0] q;
        q = x[7:3];
        if (q >= 5'd24) q = q - 5'd24;
        if (q >= 5'd12) q = q - 5'd12;
        if (q >= 5'd6)  q = q - 5'd6;
        if (q >= 5'd3)  q = q - 5'd3;
        return {q[1:0], x[2:0]};
    endfunction

endpackage

### hw/rtl/turtle_command_interpreter_unit.sv
// Turtle command interpreter, top level. One character is taken per transaction and the
// block works on it alone until done. Digits, 'd' and ignored characters are decoded, with a
// check for a pending line when end_of_input is set. Commands other than 'u', '[' and ']'
// are decoded, then carried out. A flushed line adds steps where one shared multiplier forms
// the x then the y product, each followed by a saturating add, then the result register is
// loaded after any output wait; 'u' adds the multiply and add steps for its move, which emits
// nothing. A push of n entries loads a counter, writes one entry a cycle into the single-port
// stack memory, then checks the counter; a pop reads, then loads, as the memory read is
// registered, and does neither for a zero repeat count. A stack error waits on the output
// register. An error result halts the block until reset; later characters are taken and
// dropped. Stack contents need no clearing pass: only entries below the fill count are ever read.
module turtle_command_interpreter_unit #(
    parameter int STACK_DEPTH = tci_pkg::STACK_DEPTH_DEF,
    parameter int COUNT_BITS  = tci_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS   = tci_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tci_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output tci_pkg::out_item_t out_data
);
    tci_pkg::dp_cmd_t  cmd;
    tci_pkg::dp_stat_t stat;

    // sequencing
    tci_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat)
    );

    // arithmetic, stack and output register
    tci_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .COUNT_BITS  (COUNT_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### hw/rtl/tci_dp.sv
// datapath: position, heading, counters, shared multiplier, stack memory, output register
`include "turtle_command_interpreter_unit_assert.svh"
module tci_dp #(
    parameter int STACK_DEPTH = tci_pkg::STACK_DEPTH_DEF,
    parameter int COUNT_BITS  = tci_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS   = tci_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tci_pkg::dp_cmd_t    cmd,
    output tci_pkg::dp_stat_t   stat,
    output logic                out_valid,
    input  logic                out_stall,
    output tci_pkg::out_item_t  out_data
);
    localparam int PB  = tci_pkg::POS_BITS;
    localparam int CB  = COUNT_BITS;
    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW  = $clog2(STACK_DEPTH + 1);
    localparam int MW  = FRAC_BITS + 1;
    localparam int PW  = CB + MW;
    localparam int SW  = ((PW > PB) ? PW : PB) + 2;
    localparam int CW  = ((CB > FW) ? CB : FW) + 1;
    localparam int DPW = CB + 4;
    localparam int EW  = 2 * PB + 5;

    localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};
    localparam logic [4:0] MAX_MOD = 5'(((longint'(1) << COUNT_BITS) - 1) % 24);
    localparam logic signed [SW-1:0] POS_HI = SW'((longint'(1) << (PB - 1)) - 1);
    localparam logic signed [SW-1:0] POS_LO = SW'(-(longint'(1) << (PB - 1)));

    // trig magnitudes; the eighth entry wraps to the first
    localparam logic [MW-1:0] TRIG [8] = '{
        MW'(tci_pkg::trig_q(0, FRAC_BITS)), MW'(tci_pkg::trig_q(1, FRAC_BITS)),
        MW'(tci_pkg::trig_q(2, FRAC_BITS)), MW'(tci_pkg::trig_q(3, FRAC_BITS)),
        MW'(tci_pkg::trig_q(4, FRAC_BITS)), MW'(tci_pkg::trig_q(5, FRAC_BITS)),
        MW'(tci_pkg::trig_q(6, FRAC_BITS)), MW'(tci_pkg::trig_q(0, FRAC_BITS))
    };

    logic signed [PB-1:0] pos_x_reg, pos_y_reg;
    logic [4:0]           heading_reg;
    logic [CB-1:0]        rep_reg;
    logic [4:0]           rep_mod_reg;
    logic [CB-1:0]        pend_reg;
    logic [FW-1:0]        fill_reg;
    logic                 out_valid_reg;

    logic [CB-1:0]        rep_item_reg;
    logic [4:0]           rep_item_mod_reg;
    logic [CB-1:0]        cnt_reg;
    logic [PW-1:0]        prod_reg;
    logic signed [PB-1:0] seg_sx_reg, seg_sy_reg;
    logic [EW-1:0]        rd_reg;
    tci_pkg::out_item_t   out_reg;

    logic [EW-1:0]        mem [STACK_DEPTH];

    logic [4:0]           h;
    logic [2:0]           ix, iy;
    logic                 negx, negy;
    logic [CB-1:0]        mul_dist;
    logic [MW-1:0]        mag;
    logic signed [SW-1:0] acc, prod_s, sum;
    logic signed [PB-1:0] sat_pos;
    logic                 add_neg;
    logic [DPW-1:0]       dig_prod;
    logic [CB:0]          draw_sum;
    logic [5:0]           hsum_l, hsum_r;
    logic [FW-1:0]        pop_fill;

    // heading to direction: table index and sign per quadrant
    always_comb
    begin
        h = heading_reg;
        if (h < 5'd7)
        begin
            ix = 3'(h);            iy = 3'(5'd6 - h);  negx = 1'b1; negy = 1'b1;
        end
        else if (h < 5'd13)
        begin
            ix = 3'(5'd12 - h);    iy = 3'(h - 5'd6);  negx = 1'b1; negy = 1'b0;
        end
        else if (h < 5'd19)
        begin
            ix = 3'(h - 5'd12);    iy = 3'(5'd18 - h); negx = 1'b0; negy = 1'b0;
        end
        else
        begin
            ix = 3'(5'd24 - h);    iy = 3'(h - 5'd18); negx = 1'b0; negy = 1'b1;
        end
    end

    // shared multiplier operands and saturating coordinate adder
    always_comb
    begin
        mul_dist = cmd.move_dist ? rep_item_reg : pend_reg;
        mag      = (cmd.op == tci_pkg::OP_MUL_X) ? TRIG[ix] : TRIG[iy];
        add_neg  = (cmd.op == tci_pkg::OP_ADD_X) ? negx : negy;
        acc      = (cmd.op == tci_pkg::OP_ADD_X) ? SW'(pos_x_reg) : SW'(pos_y_reg);
        prod_s   = $signed({{(SW-PW){1'b0}}, prod_reg});
        sum      = add_neg ? (acc - prod_s) : (acc + prod_s);
        if (sum > POS_HI)
            sat_pos = PB'(POS_HI);
        else if (sum < POS_LO)
            sat_pos = PB'(POS_LO);
        else
            sat_pos = sum[PB-1:0];
    end

    // repeat, pending distance, heading and stack fill arithmetic
    always_comb
    begin
        dig_prod = DPW'(rep_reg) * DPW'(cmd.digit);
        draw_sum = (CB+1)'(pend_reg) + (CB+1)'(rep_reg);
        hsum_l   = 6'(heading_reg) + 6'(rep_item_mod_reg);
        hsum_r   = 6'(heading_reg) + 6'd24 - 6'(rep_item_mod_reg);
        pop_fill = fill_reg - FW'(rep_item_reg);
    end

    // status
    always_comb
    begin
        stat.pending_nz = (pend_reg != '0);
        stat.push_ovf   = CW'(rep_item_reg) > (CW'(STACK_DEPTH) - CW'(fill_reg));
        stat.pop_unf    = CW'(rep_item_reg) > CW'(fill_reg);
        stat.rep_zero   = (rep_item_reg == '0);
        stat.push_done  = (cnt_reg == '0);
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    // turtle state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            rep_reg       <= CB'(1);
            rep_mod_reg   <= 5'd1;
            pend_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_stall)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                tci_pkg::OP_DIGIT:
                begin
                    if (dig_prod > DPW'(COUNT_MAX))
                    begin
                        rep_reg     <= COUNT_MAX;
                        rep_mod_reg <= MAX_MOD;
                    end
                    else
                    begin
                        rep_reg     <= dig_prod[CB-1:0];
                        rep_mod_reg <= tci_pkg::mod24(8'(rep_mod_reg) * 8'(cmd.digit));
                    end
                end
                tci_pkg::OP_DRAW:
                begin
                    pend_reg    <= draw_sum[CB] ? COUNT_MAX : draw_sum[CB-1:0];
                    rep_reg     <= CB'(1);
                    rep_mod_reg <= 5'd1;
                end
                tci_pkg::OP_REP_CLEAR:
                begin
                    rep_reg     <= CB'(1);
                    rep_mod_reg <= 5'd1;
                end
                tci_pkg::OP_ADD_X:
                    pos_x_reg <= sat_pos;
                tci_pkg::OP_ADD_Y:
                    pos_y_reg <= sat_pos;
                tci_pkg::OP_EMIT_SEG:
                begin
                    pend_reg      <= '0;
                    out_valid_reg <= 1'b1;
                end
                tci_pkg::OP_HOME:
                begin
                    pos_x_reg   <= '0;
                    pos_y_reg   <= '0;
                    heading_reg <= '0;
                end
                tci_pkg::OP_ORIGIN:
                begin
                    pos_x_reg <= '0;
                    pos_y_reg <= '0;
                end
                tci_pkg::OP_PUSH:
                    fill_reg <= fill_reg + FW'(1);
                tci_pkg::OP_POP_RD:
                    fill_reg <= pop_fill;
                tci_pkg::OP_POP_LD:
                begin
                    pos_x_reg   <= rd_reg[EW-1 -: PB];
                    pos_y_reg   <= rd_reg[EW-PB-1 -: PB];
                    heading_reg <= rd_reg[4:0];
                end
                tci_pkg::OP_TURN_L:
                    heading_reg <= 5'((hsum_l >= 6'd24) ? (hsum_l - 6'd24) : hsum_l);
                tci_pkg::OP_TURN_R:
                    heading_reg <= 5'((hsum_r >= 6'd24) ? (hsum_r - 6'd24) : hsum_r);
                tci_pkg::OP_EMIT_ERR:
                    out_valid_reg <= 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.snap)
        begin
            rep_item_reg     <= rep_reg;
            rep_item_mod_reg <= rep_mod_reg;
        end
        case (cmd.op)
            tci_pkg::OP_MUL_X:
            begin
                prod_reg   <= PW'(mul_dist) * PW'(mag);
                seg_sx_reg <= pos_x_reg;
                seg_sy_reg <= pos_y_reg;
            end
            tci_pkg::OP_ADD_X:
                prod_reg <= PW'(mul_dist) * PW'(mag);
            tci_pkg::OP_PUSH_INIT:
                cnt_reg <= rep_item_reg;
            tci_pkg::OP_PUSH:
                cnt_reg <= cnt_reg - CB'(1);
            tci_pkg::OP_EMIT_SEG:
            begin
                out_reg.kind    <= tci_pkg::KIND_SEGMENT;
                out_reg.start_x <= seg_sx_reg;
                out_reg.start_y <= seg_sy_reg;
                out_reg.end_x   <= pos_x_reg;
                out_reg.end_y   <= pos_y_reg;
                out_reg.last    <= cmd.seg_last;
            end
            tci_pkg::OP_EMIT_ERR:
            begin
                out_reg.kind    <= cmd.err_kind;
                out_reg.start_x <= '0;
                out_reg.start_y <= '0;
                out_reg.end_x   <= '0;
                out_reg.end_y   <= '0;
                out_reg.last    <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // stack memory, one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.op == tci_pkg::OP_PUSH)
            mem[fill_reg[AW-1:0]] <= {pos_x_reg, pos_y_reg, heading_reg};
        if (cmd.op == tci_pkg::OP_POP_RD)
            rd_reg <= mem[pop_fill[AW-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `TCI_ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_reg <= FW'(STACK_DEPTH), "stack fill beyond depth")
    `TCI_ASSERT_IMPLIES(a_emit_free, (cmd.op == tci_pkg::OP_EMIT_SEG) || (cmd.op == tci_pkg::OP_EMIT_ERR), !out_valid_reg || !out_stall, "result written over a held transaction")
    `TCI_ASSERT_NEXT(a_err_out, cmd.op == tci_pkg::OP_EMIT_ERR, out_valid_reg && (out_reg.kind != tci_pkg::KIND_SEGMENT) && out_reg.last, "error result not presented")
    `TCI_ASSERT_IMPLIES(a_pop_range, cmd.op == tci_pkg::OP_POP_RD, !stat.pop_unf && !stat.rep_zero, "pop outside the filled stack")

endmodule

### hw/rtl/tci_ctrl.sv
// controller: character decode and command sequencing
module tci_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tci_pkg::in_item_t  in_data,
    output tci_pkg::dp_cmd_t   cmd,
    input  tci_pkg::dp_stat_t  stat
);
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_D   = 8'h64;
    localparam logic [7:0] CH_U   = 8'h75;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_O   = 8'h6F;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_RBR = 8'h5D;
    localparam logic [7:0] CH_LT  = 8'h3C;
    localparam logic [7:0] CH_GT  = 8'h3E;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EOI_CHK,
        S_MUL_X,
        S_ADD_X,
        S_ADD_Y,
        S_EMIT_SEG,
        S_ACT,
        S_PUSH,
        S_POP_RD,
        S_POP_LD,
        S_EMIT_ERR
    } state_t;

    typedef enum logic [1:0] {
        MODE_PRE,
        MODE_POST,
        MODE_MOVE
    } mode_t;

    state_t     state_reg, state_next;
    mode_t      mode_reg, mode_next;
    logic [7:0] char_reg, char_next;
    logic       eoi_reg, eoi_next;
    logic       halted_reg, halted_next;

    logic is_digit, is_cmd, err_ahead;

    // character classes
    always_comb
    begin
        is_digit  = (char_reg >= CH_0) && (char_reg <= CH_9);
        is_cmd    = (char_reg == CH_U) || (char_reg == CH_R) || (char_reg == CH_O) ||
                    (char_reg == CH_LBR) || (char_reg == CH_RBR) ||
                    (char_reg == CH_LT) || (char_reg == CH_GT);
        err_ahead = ((char_reg == CH_LBR) && stat.push_ovf) ||
                    ((char_reg == CH_RBR) && stat.pop_unf);
    end

    // next state and datapath command
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        char_next   = char_reg;
        eoi_next    = eoi_reg;
        halted_next = halted_reg;
        cmd         = '0;
        cmd.op      = tci_pkg::OP_NONE;
        cmd.move_dist = (mode_reg == MODE_MOVE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    char_next  = in_data.char_code;
                    eoi_next   = in_data.end_of_input;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.snap = 1'b1;
                if (halted_reg)
                    state_next = S_IDLE;
                else if (is_digit)
                begin
                    cmd.op     = tci_pkg::OP_DIGIT;
                    cmd.digit  = char_reg[3:0];
                    state_next = eoi_reg ? S_EOI_CHK : S_IDLE;
                end
                else if (char_reg == CH_D)
                begin
                    cmd.op     = tci_pkg::OP_DRAW;
                    state_next = eoi_reg ? S_EOI_CHK : S_IDLE;
                end
                else if (is_cmd)
                begin
                    cmd.op = tci_pkg::OP_REP_CLEAR;
                    if (stat.pending_nz)
                    begin
                        mode_next  = MODE_PRE;
                        state_next = S_MUL_X;
                    end
                    else
                        state_next = S_ACT;
                end
                else
                    state_next = eoi_reg ? S_EOI_CHK : S_IDLE;
            end
            S_EOI_CHK:
            begin
                if (stat.pending_nz)
                begin
                    mode_next  = MODE_POST;
                    state_next = S_MUL_X;
                end
                else
                    state_next = S_IDLE;
            end
            S_MUL_X:
            begin
                cmd.op     = tci_pkg::OP_MUL_X;
                state_next = S_ADD_X;
            end
            S_ADD_X:
            begin
                cmd.op     = tci_pkg::OP_ADD_X;
                state_next = S_ADD_Y;
            end
            S_ADD_Y:
            begin
                cmd.op     = tci_pkg::OP_ADD_Y;
                state_next = (mode_reg == MODE_MOVE) ? S_IDLE : S_EMIT_SEG;
            end
            S_EMIT_SEG:
            begin
                if (stat.out_free)
                begin
                    cmd.op       = tci_pkg::OP_EMIT_SEG;
                    cmd.seg_last = (mode_reg == MODE_POST) || !err_ahead;
                    state_next   = (mode_reg == MODE_PRE) ? S_ACT : S_IDLE;
                end
            end
            S_ACT:
            begin
                state_next = S_IDLE;
                case (char_reg)
                    CH_U:
                    begin
                        mode_next  = MODE_MOVE;
                        state_next = S_MUL_X;
                    end
                    CH_R:  cmd.op = tci_pkg::OP_HOME;
                    CH_O:  cmd.op = tci_pkg::OP_ORIGIN;
                    CH_LBR:
                    begin
                        if (stat.push_ovf)
                            state_next = S_EMIT_ERR;
                        else
                        begin
                            cmd.op     = tci_pkg::OP_PUSH_INIT;
                            state_next = S_PUSH;
                        end
                    end
                    CH_RBR:
                    begin
                        if (stat.pop_unf)
                            state_next = S_EMIT_ERR;
                        else if (!stat.rep_zero)
                            state_next = S_POP_RD;
                    end
                    CH_LT: cmd.op = tci_pkg::OP_TURN_L;
                    CH_GT: cmd.op = tci_pkg::OP_TURN_R;
                    default:
                    begin
                    end
                endcase
            end
            S_PUSH:
            begin
                if (stat.push_done)
                    state_next = S_IDLE;
                else
                    cmd.op = tci_pkg::OP_PUSH;
            end
            S_POP_RD:
            begin
                cmd.op     = tci_pkg::OP_POP_RD;
                state_next = S_POP_LD;
            end
            S_POP_LD:
            begin
                cmd.op     = tci_pkg::OP_POP_LD;
                state_next = S_IDLE;
            end
            S_EMIT_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.op       = tci_pkg::OP_EMIT_ERR;
                    cmd.err_kind = (char_reg == CH_LBR) ? tci_pkg::KIND_OVERFLOW
                                                        : tci_pkg::KIND_UNDERFLOW;
                    halted_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state and registered controls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= MODE_PRE;
            char_reg   <= '0;
            eoi_reg    <= 1'b0;
            halted_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            char_reg   <= char_next;
            eoi_reg    <= eoi_next;
            halted_reg <= halted_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

### bench/testbench.sv
// self-checking testbench of the turtle command interpreter
`timescale 1ns / 100ps

module testbench;

    localparam int DEPTH      = 32;
    localparam int CNT_MAX    = 65535;
    localparam int RAND_ITEMS = 1750;
    localparam int WDOG_LIMIT = 20000;

    localparam logic [7:0] CH_DRAW   = 8'h64;
    localparam logic [7:0] CH_MOVE   = 8'h75;
    localparam logic [7:0] CH_HOME   = 8'h72;
    localparam logic [7:0] CH_ORIGIN = 8'h6f;
    localparam logic [7:0] CH_PUSH   = 8'h5b;
    localparam logic [7:0] CH_POP    = 8'h5d;
    localparam logic [7:0] CH_LEFT   = 8'h3c;
    localparam logic [7:0] CH_RIGHT  = 8'h3e;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam longint POS_HI = (64'sd1 <<< 39) - 1;
    localparam longint POS_LO = -(64'sd1 <<< 39);

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    tci_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    tci_pkg::out_item_t out_data;

    turtle_command_interpreter_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    // turtle state mirror
    longint     tx, ty;
    int         hdg;
    longint     rep_cnt;
    longint     pend_dist;
    longint     stk_x [DEPTH];
    longint     stk_y [DEPTH];
    int         stk_h [DEPTH];
    int         fill;
    bit         halted;

    tci_pkg::in_item_t   char_queue [$];
    tci_pkg::out_item_t  segment_queue [$];
    int         fail_count;
    int         seg_count;
    int         err_count;
    int         in_count;
    bit         stim_done;
    int         idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint sin_fix(input int i);
        longint v;
        case (i)
            0: v = 0;
            1: v = 25882;
            2: v = 50000;
            3: v = 70711;
            4: v = 86603;
            5: v = 96593;
            default: v = 100000;
        endcase
        return ((v << 16) + 50000) / 100000;
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_HI) return POS_HI;
        if (v < POS_LO) return POS_LO;
        return v;
    endfunction

    // move the turtle by steps along the current heading
    function automatic void walk(input longint steps);
        longint dx, dy;
        if (hdg < 7)
        begin
            dx = -sin_fix(hdg);      dy = -sin_fix(6 - hdg);
        end
        else if (hdg < 13)
        begin
            dx = -sin_fix(12 - hdg); dy = sin_fix(hdg - 6);
        end
        else if (hdg < 19)
        begin
            dx = sin_fix(hdg - 12);  dy = sin_fix(18 - hdg);
        end
        else
        begin
            dx = sin_fix(24 - hdg);  dy = -sin_fix(hdg - 18);
        end
        tx = clamp_pos(tx + steps * dx);
        ty = clamp_pos(ty + steps * dy);
    endfunction

    function automatic void push_result(input logic [1:0] k, input longint sx, input longint sy,
                                        input longint ex, input longint ey);
        tci_pkg::out_item_t r;
        r.kind    = k;
        r.start_x = sx[39:0];
        r.start_y = sy[39:0];
        r.end_x   = ex[39:0];
        r.end_y   = ey[39:0];
        r.last    = 1'b0;
        segment_queue.push_back(r);
    endfunction

    function automatic void flush_line();
        longint sx, sy;
        if (pend_dist > 0)
        begin
            sx = tx;
            sy = ty;
            walk(pend_dist);
            push_result(tci_pkg::KIND_SEGMENT, sx, sy, tx, ty);
            pend_dist = 0;
            seg_count++;
        end
    endfunction

    // expected segments and errors of one character
    function automatic void interpret_char(input tci_pkg::in_item_t it);
        longint rep;
        int     n0;
        int     c;
        n0 = segment_queue.size();
        if (halted) return;
        c = it.char_code;
        rep = rep_cnt;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            rep_cnt = rep * (c - 8'h30);
            if (rep_cnt > CNT_MAX) rep_cnt = CNT_MAX;
        end
        else if (c == CH_DRAW)
        begin
            pend_dist = pend_dist + rep;
            if (pend_dist > CNT_MAX) pend_dist = CNT_MAX;
            rep_cnt = 1;
        end
        else if (c == CH_MOVE || c == CH_HOME || c == CH_ORIGIN || c == CH_PUSH
                 || c == CH_POP || c == CH_LEFT || c == CH_RIGHT)
        begin
            flush_line();
            rep_cnt = 1;
            case (c)
                CH_MOVE:   walk(rep);
                CH_HOME:   begin tx = 0; ty = 0; hdg = 0; end
                CH_ORIGIN: begin tx = 0; ty = 0; end
                CH_PUSH:
                    if (rep > DEPTH - fill)
                    begin
                        push_result(tci_pkg::KIND_OVERFLOW, 0, 0, 0, 0);
                        halted = 1'b1;
                        err_count++;
                    end
                    else
                        for (int i = 0; i < rep; i++)
                        begin
                            stk_x[fill] = tx;
                            stk_y[fill] = ty;
                            stk_h[fill] = hdg;
                            fill++;
                        end
                CH_POP:
                    if (rep > fill)
                    begin
                        push_result(tci_pkg::KIND_UNDERFLOW, 0, 0, 0, 0);
                        halted = 1'b1;
                        err_count++;
                    end
                    else if (rep > 0)
                    begin
                        fill = fill - int'(rep);
                        tx = stk_x[fill];
                        ty = stk_y[fill];
                        hdg = stk_h[fill];
                    end
                CH_LEFT:   hdg = (hdg + int'(rep % 24)) % 24;
                default:   hdg = (hdg + 24 - int'(rep % 24)) % 24;
            endcase
        end
        if (it.end_of_input) flush_line();
        if (segment_queue.size() > n0)
            segment_queue[segment_queue.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_char(input logic [7:0] c, input logic eoi);
        tci_pkg::in_item_t it;
        it.char_code    = c;
        it.end_of_input = eoi;
        char_queue.push_back(it);
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return 8'(8'h30 + $urandom_range(1, 9));
        if (r < 27) return CH_ZERO;
        if (r < 45) return CH_DRAW;
        if (r < 53) return CH_MOVE;
        if (r < 63) return CH_PUSH;
        if (r < 72) return CH_POP;
        if (r < 80) return CH_LEFT;
        if (r < 88) return CH_RIGHT;
        if (r < 90) return CH_HOME;
        if (r < 92) return CH_ORIGIN;
        return 8'($urandom_range(0, 255));
    endfunction

    // stimulus: directed part, then a random program that stays clear of stack errors until near its end
    initial
    begin
        longint g_rep;
        int     g_fill;
        rst_n = 1'b0;
        // saturating counts, turns, zero repeat and a short push and pop
        add_char(8'h39, 1'b0); add_char(8'h39, 1'b0); add_char(8'h39, 1'b0);
        add_char(8'h39, 1'b0); add_char(8'h39, 1'b0); add_char(8'h39, 1'b0);
        add_char(CH_DRAW, 1'b0); add_char(CH_DRAW, 1'b0); add_char(8'hff, 1'b0);
        add_char(8'h37, 1'b0); add_char(CH_LEFT, 1'b0);
        add_char(8'h35, 1'b0); add_char(CH_RIGHT, 1'b1);
        add_char(8'h00, 1'b1); add_char(CH_ZERO, 1'b0); add_char(CH_MOVE, 1'b0);
        add_char(CH_DRAW, 1'b0); add_char(CH_ORIGIN, 1'b0);
        add_char(CH_PUSH, 1'b0); add_char(CH_DRAW, 1'b0); add_char(CH_POP, 1'b1);
        add_char(CH_HOME, 1'b0); add_char(8'h80, 1'b0);
        add_char(8'h39, 1'b0); add_char(CH_MOVE, 1'b1);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // the directed part leaves a repeat count of one and an empty stack
        g_rep  = 1;
        g_fill = 0;
        // pushes and pops that would fail become turns, except near the end
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            logic [7:0] c;
            bit         tail;
            c = pick_char();
            tail = (n > RAND_ITEMS - 40);
            if (tail && $urandom_range(0, 3) == 0) c = CH_POP;
            if (!tail && ((c == CH_PUSH && g_rep > DEPTH - g_fill) ||
                          (c == CH_POP && g_rep > g_fill)))
                c = CH_LEFT;
            if (c >= CH_ZERO && c <= 8'h39)
            begin
                g_rep = g_rep * longint'(c - CH_ZERO);
                if (g_rep > CNT_MAX) g_rep = CNT_MAX;
            end
            else if (c == CH_DRAW || c == CH_MOVE || c == CH_HOME || c == CH_ORIGIN ||
                     c == CH_PUSH || c == CH_POP || c == CH_LEFT || c == CH_RIGHT)
            begin
                if (c == CH_PUSH) g_fill = g_fill + int'(g_rep);
                if (c == CH_POP)  g_fill = g_fill - int'(g_rep);
                g_rep = 1;
            end
            add_char(c, $urandom_range(0, 7) == 0);
        end
        // a halted block swallows the rest
        add_char(8'h39, 1'b0); add_char(CH_POP, 1'b0); add_char(CH_DRAW, 1'b1);
        stim_done = 1'b1;
    end

    // driver
    int                 in_gap;
    tci_pkg::in_item_t  cur_item;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                interpret_char(in_data);
                in_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0 || (!in_valid && in_gap < 0))
                begin
                    in_valid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end
                else if (char_queue.size() > 0 && in_gap == 0)
                begin
                    cur_item = char_queue.pop_front();
                    in_valid <= 1'b1;
                    in_data  <= cur_item;
                    in_gap   <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    in_gap   <= 0;
                end
            end
        end
    end

    // monitor with random output stall
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                tci_pkg::out_item_t e;
                if (segment_queue.size() == 0)
                begin
                    $error("unexpected result kind=%0d", out_data.kind);
                    fail_count++;
                end
                else
                begin
                    e = segment_queue.pop_front();
                    if (out_data.kind !== e.kind)
                        begin $error("kind exp %0d got %0d", e.kind, out_data.kind); fail_count++; end
                    if (out_data.start_x !== e.start_x)
                        begin $error("start_x exp %0d got %0d", e.start_x, out_data.start_x); fail_count++; end
                    if (out_data.start_y !== e.start_y)
                        begin $error("start_y exp %0d got %0d", e.start_y, out_data.start_y); fail_count++; end
                    if (out_data.end_x !== e.end_x)
                        begin $error("end_x exp %0d got %0d", e.end_x, out_data.end_x); fail_count++; end
                    if (out_data.end_y !== e.end_y)
                        begin $error("end_y exp %0d got %0d", e.end_y, out_data.end_y); fail_count++; end
                    if (out_data.last !== e.last)
                        begin $error("last exp %0d got %0d", e.last, out_data.last); fail_count++; end
                end
            end
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            end
        end
    end

    // watchdog and end of run
    initial
    begin
        tx = 0; ty = 0; hdg = 0; rep_cnt = 1; pend_dist = 0; fill = 0; halted = 1'b0;
        fail_count = 0; seg_count = 0; err_count = 0; in_count = 0;
        stim_done = 1'b0; idle_cycles = 0;
        @(posedge rst_n);
        while (!(stim_done && char_queue.size() == 0 && !in_valid && segment_queue.size() == 0)
               && idle_cycles < WDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("[turtle_command_interpreter_unit] ERROR");
            $finish;
        end
        else
        begin
            repeat (100) @(posedge clk);
            $display("characters sent %0d, segments checked %0d, stack errors %0d",
                     in_count, seg_count, err_count);
            if (fail_count == 0 && !out_valid)
                $display("[turtle_command_interpreter_unit] OK");
            else
                $display("[turtle_command_interpreter_unit] ERROR");
            $finish;
        end
    end

endmodule

### turtle_command_interpreter_unit.f
+incdir+hw/rtl
hw/rtl/tci_pkg.sv
hw/rtl/tci_dp.sv
hw/rtl/tci_ctrl.sv
hw/rtl/turtle_command_interpreter_unit.sv
bench/testbench.sv
